[hdl/dger_pkg.sv]
// shared types, widths and constants for the disk graph escape reachability block
`default_nettype none

package dger_pkg;

  // default depth of the point store
  localparam int DEFAULT_MAX_POINTS = 128;

  // widths of the fixed-point arithmetic, all in half units
  localparam int COORD_W    = 8;
  localparam int JUMP_W     = 8;
  localparam int REACH_W    = 9;
  localparam int REACH_SQ_W = 17;
  localparam int DIFF_W     = 9;
  localparam int DIFF_SQ_W  = 16;
  localparam int DIST_SQ_W  = 17;
  localparam int EDGE_SUM_W = 10;

  // island radius and lake half-side, half units
  localparam logic [REACH_W-1:0]    ISLAND_RADIUS = 9'd15;
  localparam logic [EDGE_SUM_W-1:0] LAKE_HALF     = 10'd100;

  // one input item
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      point_present;
    logic                      last_point;
  } point_item_t;

  // one result item
  typedef struct packed {
    logic can_reach_edge;
    logic overflow;
  } result_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic seed;
    logic square;
    logic scan_issue;
    logic pop;
    logic fetch;
    logic take_cur;
    logic finish;
    logic found;
  } dger_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
    logic stack_empty;
    logic edge_hit;
    logic out_free;
  } dger_status_t;

endpackage

`default_nettype wire

[hdl/dger_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module dger_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/dger_ctrl.sv]
// controller state machine: loading, search sequencing and result hand-off
`default_nettype none

module dger_ctrl
  import dger_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_last,
  output logic         in_ready,
  input  dger_status_t status,
  output dger_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SQUARE,
    S_SCAN,
    S_DRAIN,
    S_POP,
    S_FETCH,
    S_TAKE,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   found, found_next;
  logic   accept;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    found_next = found;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        cmd.accept = accept;
        if (accept && in_last) begin
          cmd.seed   = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        if (status.edge_hit) begin
          found_next = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_DRAIN;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (status.stack_empty) begin
          found_next = 1'b0;
          state_next = S_FINISH;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.take_cur = 1'b1;
        state_next   = S_SQUARE;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
    cmd.found = found;
  end

  // state and registered verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

endmodule

`default_nettype wire

[hdl/dger_datapath.sv]
// datapath: point store, visited marks, pending stack, distance pipeline, result register
`default_nettype none

module dger_datapath
  import dger_pkg::*;
#(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst,
  input  dger_cmd_t         cmd,
  output dger_status_t      status,
  input  point_item_t       in_item,
  input  logic              cfg_valid,
  input  logic [JUMP_W-1:0] cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output result_item_t      out_item
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_POINTS);

  function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  logic [JUMP_W-1:0]         jump_distance;
  logic [CW-1:0]             count;
  logic                      ovf;
  logic [CW-1:0]             scan_idx;
  logic [CW-1:0]             top;
  logic [CW-1:0]             top_dec;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic [REACH_W-1:0]        reach;
  logic [REACH_SQ_W-1:0]     reach_sq;
  logic [2*REACH_W-1:0]      reach_prod;

  // distance pipeline
  logic                      s1_valid;
  logic [IW-1:0]             s1_idx;
  logic                      s2_valid;
  logic [IW-1:0]             s2_idx;
  logic                      s2_vis;
  logic signed [DIFF_W-1:0]  s2_dx, s2_dy;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
  logic                      s3_valid;
  logic [IW-1:0]             s3_idx;
  logic [DIFF_SQ_W-1:0]      s3_sqx, s3_sqy;
  logic [DIST_SQ_W-1:0]      dist_sq;
  logic                      hit;
  logic                      push;

  // memory ports
  logic                      store_point;
  logic [2*COORD_W-1:0]      pt_rdata;
  logic [IW-1:0]             pt_raddr;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic                      vis_we;
  logic [IW-1:0]             vis_waddr;
  logic                      vis_rdata;
  logic [IW-1:0]             stk_rdata;

  logic [EDGE_SUM_W-1:0]     edge_sum_x, edge_sum_y;

  assign store_point = cmd.accept && in_item.point_present && (count < COUNT_MAX);
  assign top_dec     = top - CW'(1);
  assign pt_raddr    = cmd.fetch ? stk_rdata : scan_idx[IW-1:0];
  assign rd_x        = pt_rdata[2*COORD_W-1 -: COORD_W];
  assign rd_y        = pt_rdata[COORD_W-1:0];

  // point coordinates, one word per point
  dger_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk  (clk),
    .we   (store_point),
    .waddr(count[IW-1:0]),
    .wdata({in_item.point_x, in_item.point_y}),
    .raddr(pt_raddr),
    .rdata(pt_rdata)
  );

  // visited marks: cleared as each point is loaded, set on a hit
  assign vis_we    = store_point || hit;
  assign vis_waddr = hit ? s3_idx : count[IW-1:0];

  dger_ram #(
    .WIDTH(1),
    .DEPTH(MAX_POINTS)
  ) u_visited (
    .clk  (clk),
    .we   (vis_we),
    .waddr(vis_waddr),
    .wdata(hit),
    .raddr(scan_idx[IW-1:0]),
    .rdata(vis_rdata)
  );

  // pending stack of point indexes
  assign push = hit && (top < COUNT_MAX);

  dger_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_POINTS)
  ) u_stack (
    .clk  (clk),
    .we   (push),
    .waddr(top[IW-1:0]),
    .wdata(s3_idx),
    .raddr(top_dec[IW-1:0]),
    .rdata(stk_rdata)
  );

  // squares and distance compare
  assign sqx_full   = s2_dx * s2_dx;
  assign sqy_full   = s2_dy * s2_dy;
  assign reach_prod = reach * reach;
  assign dist_sq    = DIST_SQ_W'(s3_sqx) + DIST_SQ_W'(s3_sqy);
  assign hit        = s3_valid && (dist_sq <= reach_sq);

  // edge test of the current position
  assign edge_sum_x = EDGE_SUM_W'(mag(cur_x)) + EDGE_SUM_W'(reach);
  assign edge_sum_y = EDGE_SUM_W'(mag(cur_y)) + EDGE_SUM_W'(reach);

  // status to the controller
  assign status.scan_done   = (scan_idx == count);
  assign status.pipe_busy   = s1_valid || s2_valid || s3_valid;
  assign status.stack_empty = (top == '0);
  assign status.edge_hit    = (edge_sum_x >= LAKE_HALF) || (edge_sum_y >= LAKE_HALF);
  assign status.out_free    = !out_valid || out_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_distance <= '0;
      count         <= '0;
      ovf           <= 1'b0;
      scan_idx      <= '0;
      top           <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        jump_distance <= cfg_data;
      end
      if (store_point) begin
        count <= count + CW'(1);
      end else if (cmd.accept && in_item.point_present) begin
        ovf <= 1'b1;
      end
      if (cmd.square) begin
        scan_idx <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (cmd.seed) begin
        top <= '0;
      end else if (cmd.pop) begin
        top <= top_dec;
      end else if (push) begin
        top <= top + CW'(1);
      end
      s1_valid <= cmd.scan_issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && !s2_vis;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        count     <= '0;
        ovf       <= 1'b0;
        top       <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      cur_x <= '0;
      cur_y <= '0;
      reach <= REACH_W'(jump_distance) + ISLAND_RADIUS;
    end else if (cmd.take_cur) begin
      cur_x <= rd_x;
      cur_y <= rd_y;
      reach <= REACH_W'(jump_distance);
    end
    if (cmd.square) begin
      reach_sq <= reach_prod[REACH_SQ_W-1:0];
    end
    s1_idx <= scan_idx[IW-1:0];
    s2_idx <= s1_idx;
    s2_vis <= vis_rdata;
    s2_dx  <= DIFF_W'(rd_x) - DIFF_W'(cur_x);
    s2_dy  <= DIFF_W'(rd_y) - DIFF_W'(cur_y);
    s3_idx <= s2_idx;
    s3_sqx <= sqx_full[DIFF_SQ_W-1:0];
    s3_sqy <= sqy_full[DIFF_SQ_W-1:0];
    if (cmd.finish) begin
      out_item.can_reach_edge <= cmd.found;
      out_item.overflow       <= ovf;
    end
  end

  // checks
  a_stack_within_count: assert property (@(posedge clk) disable iff (rst)
    top <= count) else $error("pending stack deeper than point count");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX) else $error("point count beyond store depth");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit |-> (CW'(s3_idx) < count)) else $error("hit on an unloaded entry");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && (out_item.overflow == $past(ovf)))
    else $error("result item not presented after search");

endmodule

`default_nettype wire

[hdl/disk_graph_escape_reachability_top.sv]
// top level of the disk graph escape reachability block
// Points load at one item per clock into a store of MAX_POINTS entries; the item marked
// last_point starts a search and the block takes no item until its result is written to
// the output register. Each position examined (the island and every point reached) goes
// through these steps: the reach is squared and the shore tested, one pass is made over the
// stored points through the single read port of the point store and the pass is seen done,
// the 3-stage distance pipeline drains, and the next position is popped and fetched; once
// the stack runs empty the last pop is followed by the result write. A position within
// reach of the shore ends the search at once. A waiting result does not block loading of
// the next set; only the end of the next search waits for it to be taken.
`default_nettype none

module disk_graph_escape_reachability_top
  import dger_pkg::*;
#(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  point_item_t       in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output result_item_t      out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [JUMP_W-1:0] cfg_data
);

  dger_cmd_t    cmd;
  dger_status_t status;

  // register writes always taken
  assign cfg_ready = 1'b1;

  // sequencing
  dger_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_last (in_data.last_point),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // storage and arithmetic
  dger_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_item  (in_data),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_item (out_data)
  );

endmodule

`default_nettype wire
